### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PFP_ASSERT(lbl, prop, msg)
`define PFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/pfpaqi_pkg.sv
// Shared constants, types and the index segment table for the frame parser.
package pfpaqi_pkg;

  localparam logic [7:0] HDR_B    = 8'h42;
  localparam logic [7:0] HDR_M    = 8'h4D;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] HDR_LEN  = 8'd28;

  // frame positions (0 = hunting)
  localparam logic [4:0] POS_HUNT   = 5'd0;
  localparam logic [4:0] POS_HDR_M  = 5'd1;
  localparam logic [4:0] POS_HDR_Z  = 5'd2;
  localparam logic [4:0] POS_HDR_L  = 5'd3;
  localparam logic [4:0] POS_PM1_H  = 5'd4;
  localparam logic [4:0] POS_PM1_L  = 5'd5;
  localparam logic [4:0] POS_PM25_H = 5'd6;
  localparam logic [4:0] POS_PM25_L = 5'd7;
  localparam logic [4:0] POS_PM10_H = 5'd8;
  localparam logic [4:0] POS_PM10_L = 5'd9;
  localparam logic [4:0] POS_C03_H  = 5'd16;
  localparam logic [4:0] POS_C03_L  = 5'd17;
  localparam logic [4:0] POS_LAST   = 5'd31;

  localparam int unsigned NUM_W   = 15;  // (x - x0) * dy, at most 150 * 99
  localparam logic [3:0]  DIV_LAST = 4'(NUM_W - 1);

  typedef struct packed {
    logic       cap_en;    // byte accepted this cycle
    logic [4:0] pos;       // its frame position
    logic       seg_load;  // pick segment and form numerator
    logic       div_step;  // one quotient bit
    logic       out_load;  // move result into the output register
  } pfpaqi_cmd_t;

  typedef struct packed {
    logic out_busy;        // output register full and not taken this cycle
  } pfpaqi_stat_t;

  typedef struct packed {
    logic       pass;      // above 500: index is the raw value
    logic [8:0] x0;
    logic [7:0] dx;
    logic [8:0] y0;
    logic [6:0] dy;
  } pfpaqi_seg_t;

  function automatic pfpaqi_seg_t seg_of(input logic [15:0] x);
    pfpaqi_seg_t s;
    s = '{pass: 1'b0, x0: 9'd0, dx: 8'd12, y0: 9'd0, dy: 7'd50};
    if (x <= 16'd12) begin
      s = '{pass: 1'b0, x0: 9'd0,   dx: 8'd12,  y0: 9'd0,   dy: 7'd50};
    end else if (x <= 16'd35) begin
      s = '{pass: 1'b0, x0: 9'd13,  dx: 8'd22,  y0: 9'd51,  dy: 7'd49};
    end else if (x <= 16'd55) begin
      s = '{pass: 1'b0, x0: 9'd35,  dx: 8'd20,  y0: 9'd101, dy: 7'd49};
    end else if (x <= 16'd150) begin
      s = '{pass: 1'b0, x0: 9'd55,  dx: 8'd95,  y0: 9'd151, dy: 7'd49};
    end else if (x <= 16'd250) begin
      s = '{pass: 1'b0, x0: 9'd150, dx: 8'd100, y0: 9'd201, dy: 7'd99};
    end else if (x <= 16'd350) begin
      s = '{pass: 1'b0, x0: 9'd250, dx: 8'd100, y0: 9'd301, dy: 7'd99};
    end else if (x <= 16'd500) begin
      s = '{pass: 1'b0, x0: 9'd350, dx: 8'd150, y0: 9'd401, dy: 7'd99};
    end else begin
      s = '{pass: 1'b1, x0: 9'd0,   dx: 8'd1,   y0: 9'd0,   dy: 7'd0};
    end
    return s;
  endfunction

endpackage

### rtl/core/pfpaqi_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
interface pfpaqi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfpaqi_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pm1_value;
  logic [15:0] pm25_value;
  logic [15:0] pm10_value;
  logic [15:0] count_03_value;
  logic [15:0] aqi_value;
  modport source (output valid, output pm1_value, output pm25_value, output pm10_value,
                  output count_03_value, output aqi_value, input ready);
  modport sink   (input valid, input pm1_value, input pm25_value, input pm10_value,
                  input count_03_value, input aqi_value, output ready);
endinterface

### rtl/core/pfpaqi_ctrl.sv
// Controller: header hunt, frame position and index calculation sequencing.
module pfpaqi_ctrl
  import pfpaqi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  output logic         in_ready,
  input  pfpaqi_stat_t stat,
  output pfpaqi_cmd_t  cmd
);

  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_SEG = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       accept;
  logic [4:0] hunt;

  assign in_ready = (state_r == S_RUN);
  assign accept   = in_valid && in_ready;
  // a mismatching header byte is itself checked as a possible 'B'
  assign hunt     = (in_byte == HDR_B) ? POS_HDR_M : POS_HUNT;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_RUN: begin
        if (accept) begin
          case (pos_r)
            POS_HUNT:  pos_nxt = hunt;
            POS_HDR_M: pos_nxt = (in_byte == HDR_M)    ? POS_HDR_Z : hunt;
            POS_HDR_Z: pos_nxt = (in_byte == HDR_ZERO) ? POS_HDR_L : hunt;
            POS_HDR_L: pos_nxt = (in_byte == HDR_LEN)  ? POS_PM1_H : hunt;
            POS_LAST: begin
              pos_nxt   = POS_HUNT;
              state_nxt = S_SEG;
            end
            default:   pos_nxt = pos_r + 5'd1;
          endcase
        end
      end
      S_SEG: begin
        cnt_nxt   = 4'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      pos_r   <= POS_HUNT;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    cmd.cap_en   = accept;
    cmd.pos      = pos_r;
    cmd.seg_load = (state_r == S_SEG);
    cmd.div_step = (state_r == S_DIV);
    cmd.out_load = (state_r == S_OUT) && !stat.out_busy;
  end

endmodule

### rtl/core/pfpaqi_dp.sv
// Datapath: field capture, segment multiply, bit-serial divider, output register.
module pfpaqi_dp
  import pfpaqi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   in_byte,
  input  pfpaqi_cmd_t  cmd,
  output pfpaqi_stat_t stat,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [15:0]  out_pm1,
  output logic [15:0]  out_pm25,
  output logic [15:0]  out_pm10,
  output logic [15:0]  out_c03,
  output logic [15:0]  out_aqi
);

  logic [7:0]  hi_r;
  logic [15:0] pm1_r, pm25_r, pm10_r, c03_r;
  logic [15:0] word;

  pfpaqi_seg_t seg;
  logic [7:0]  xoff;
  logic        pass_r;
  logic [7:0]  dx_r;
  logic [8:0]  y0_r;
  logic [NUM_W-1:0] num_r;   // numerator, shifted out as quotient bits come in
  logic [7:0]  rem_r;
  logic [8:0]  rem_sh;
  logic        qbit;

  logic        valid_r;
  logic [15:0] o_pm1_r, o_pm25_r, o_pm10_r, o_c03_r, o_aqi_r;
  logic [15:0] aqi;

  assign word = {hi_r, in_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r   <= '0;
      pm1_r  <= '0;
      pm25_r <= '0;
      pm10_r <= '0;
      c03_r  <= '0;
    end else if (cmd.cap_en) begin
      case (cmd.pos)
        POS_PM1_H, POS_PM25_H, POS_PM10_H, POS_C03_H: hi_r <= in_byte;
        POS_PM1_L:  pm1_r  <= word;
        POS_PM25_L: pm25_r <= word;
        POS_PM10_L: pm10_r <= word;
        POS_C03_L:  c03_r  <= word;
        default: ;
      endcase
    end
  end

  assign seg    = seg_of(pm25_r);
  assign xoff   = 8'(pm25_r[8:0] - seg.x0);
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dx_r});

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      pass_r <= seg.pass;
      dx_r   <= seg.dx;
      y0_r   <= seg.y0;
      num_r  <= NUM_W'(xoff) * NUM_W'(seg.dy);
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? 8'(rem_sh - {1'b0, dx_r}) : rem_sh[7:0];
      num_r <= {num_r[NUM_W-2:0], qbit};
    end
  end

  assign aqi = pass_r ? pm25_r : (16'(y0_r) + 16'(num_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_pm1_r  <= pm1_r;
      o_pm25_r <= pm25_r;
      o_pm10_r <= pm10_r;
      o_c03_r  <= c03_r;
      o_aqi_r  <= aqi;
    end
  end

  assign stat.out_busy = valid_r && !out_ready;
  assign out_valid     = valid_r;
  assign out_pm1       = o_pm1_r;
  assign out_pm25      = o_pm25_r;
  assign out_pm10      = o_pm10_r;
  assign out_c03       = o_c03_r;
  assign out_aqi       = o_aqi_r;

endmodule

### rtl/core/particle_frame_parser_aqi.sv
// Top level: particle sensor frame parser with PM2.5 index.
//
// in_chan carries one received serial byte per request (valid/ready). The
// block hunts for the header 'B','M',0x00,28, counts a 32-byte frame and
// captures PM1, PM2.5, PM10 and the 0.3 um count (big-endian words). Header
// bytes that do not match send it back to hunting; payload and checksum are
// not checked.
// out_chan carries one result request per complete frame: the four fields and
// the PM2.5 index (raw PM2.5 above 500).
// Ordinary bytes are accepted back to back. After the last frame byte in_ready
// drops while the segment is picked and the product formed, then a restoring
// divider produces one quotient bit a cycle, then the result enters the output
// register, which raises out_chan.valid.
// The output register holds a result while the receiver stalls and bytes of
// the next frame keep being accepted; only a second finished frame waits for
// the register to empty, with in_ready low.
// Synchronous reset (rst_n low) clears the position to hunting, the captured
// fields to zero and the output valid.
`include "assert_macros.svh"

module particle_frame_parser_aqi
  import pfpaqi_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  pfpaqi_in_if.sink     in_chan,
  pfpaqi_out_if.source  out_chan
);

  pfpaqi_cmd_t  cmd;
  pfpaqi_stat_t stat;

  pfpaqi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.rx_byte),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfpaqi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_chan.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_pm1   (out_chan.pm1_value),
    .out_pm25  (out_chan.pm25_value),
    .out_pm10  (out_chan.pm10_value),
    .out_c03   (out_chan.count_03_value),
    .out_aqi   (out_chan.aqi_value)
  );

  `PFP_ASSERT(a_no_load_while_rx, !(in_chan.ready && cmd.out_load), "load while accepting bytes")
  `PFP_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, out_chan.valid, "loaded result not valid")
  `PFP_ASSERT_NEXT(a_seg_blocks_rx, cmd.seg_load, !in_chan.ready && cmd.div_step, "bad calc start")

endmodule

### verif/particle_frame_parser_aqi_tb.sv
`timescale 1ns / 100ps
// Testbench for the particle frame parser: frames, header resync and PM2.5 index checks.
module particle_frame_parser_aqi_tb
  import pfpaqi_pkg::*;
();

  typedef struct packed {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [15:0] c03;
    logic [15:0] aqi;
  } reading_t;

  typedef logic [7:0] frame_bytes_t [32];

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pfpaqi_in_if  in_chan();
  pfpaqi_out_if out_chan();

  particle_frame_parser_aqi u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirror
  logic [5:0]  frame_pos = 6'd0;
  logic [7:0]  hi_byte   = 8'd0;
  logic [15:0] cap_pm1   = 16'd0;
  logic [15:0] cap_pm25  = 16'd0;
  logic [15:0] cap_pm10  = 16'd0;
  logic [15:0] cap_c03   = 16'd0;

  logic [7:0] header_seq [4] = '{HDR_B, HDR_M, HDR_ZERO, HDR_LEN};

  reading_t pending_readings[$];
  int mismatches     = 0;
  int bytes_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off, requested by toggling hold_toggle
  int hold_len    = 0;
  int hold_left   = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;

  function automatic logic [15:0] pm25_index(input logic [15:0] x);
    int lo_x, hi_x, lo_y, hi_y;
    if (x > 16'd500) return x;
    if (x <= 16'd12) begin
      lo_x = 0;   hi_x = 12;  lo_y = 0;   hi_y = 50;
    end else if (x <= 16'd35) begin
      lo_x = 13;  hi_x = 35;  lo_y = 51;  hi_y = 100;
    end else if (x <= 16'd55) begin
      lo_x = 35;  hi_x = 55;  lo_y = 101; hi_y = 150;
    end else if (x <= 16'd150) begin
      lo_x = 55;  hi_x = 150; lo_y = 151; hi_y = 200;
    end else if (x <= 16'd250) begin
      lo_x = 150; hi_x = 250; lo_y = 201; hi_y = 300;
    end else if (x <= 16'd350) begin
      lo_x = 250; hi_x = 350; lo_y = 301; hi_y = 400;
    end else begin
      lo_x = 350; hi_x = 500; lo_y = 401; hi_y = 500;
    end
    return 16'(lo_y + ((int'(x) - lo_x) * (hi_y - lo_y)) / (hi_x - lo_x));
  endfunction

  function automatic logic [5:0] resync_pos(input logic [7:0] b);
    return (b == HDR_B) ? 6'd1 : 6'd0;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    logic [15:0] word;
    word = {hi_byte, b};
    if (frame_pos == 6'd0 || frame_pos >= 6'd32) begin
      frame_pos = resync_pos(b);
    end else if (frame_pos == POS_HDR_M) begin
      frame_pos = (b == HDR_M) ? 6'd2 : resync_pos(b);
    end else if (frame_pos == POS_HDR_Z) begin
      frame_pos = (b == HDR_ZERO) ? 6'd3 : resync_pos(b);
    end else if (frame_pos == POS_HDR_L) begin
      frame_pos = (b == HDR_LEN) ? 6'd4 : resync_pos(b);
    end else begin
      case (frame_pos)
        POS_PM1_H, POS_PM25_H, POS_PM10_H, POS_C03_H: hi_byte = b;
        POS_PM1_L:  cap_pm1  = word;
        POS_PM25_L: cap_pm25 = word;
        POS_PM10_L: cap_pm10 = word;
        POS_C03_L:  cap_c03  = word;
        default: ;
      endcase
      if (frame_pos == POS_LAST) begin
        frame_pos = 6'd0;
        pending_readings.push_back('{cap_pm1, cap_pm25, cap_pm10, cap_c03,
                                     pm25_index(cap_pm25)});
      end else begin
        frame_pos = frame_pos + 6'd1;
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    bytes_sent++;
    track_byte(b);
  endtask

  // sender stops and waits until every expected reading has come out
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic build_frame(input logic [15:0] pm1, pm25, pm10, c03,
                             output frame_bytes_t f);
    foreach (f[i]) f[i] = 8'($urandom_range(255));
    for (int i = 0; i < 4; i++) f[i] = header_seq[i];
    {f[POS_PM1_H],  f[POS_PM1_L]}  = pm1;
    {f[POS_PM25_H], f[POS_PM25_L]} = pm25;
    {f[POS_PM10_H], f[POS_PM10_L]} = pm10;
    {f[POS_C03_H],  f[POS_C03_L]}  = c03;
  endtask

  task automatic send_frame(input frame_bytes_t f, input int first);
    for (int i = first; i < 32; i++) send_byte(f[i]);
  endtask

  function automatic logic [15:0] rand_reading();
    case ($urandom_range(9))
      0:          return 16'h0000;
      1:          return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(600));
      default:    return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic test_field_extremes();
    frame_bytes_t f;
    foreach (f[i]) f[i] = 8'h00;
    for (int i = 0; i < 4; i++) f[i] = header_seq[i];
    send_frame(f, 0);
    foreach (f[i]) f[i] = 8'hFF;
    for (int i = 0; i < 4; i++) f[i] = header_seq[i];
    send_frame(f, 0);
    drain_results();
  endtask

  task automatic test_index_breakpoints();
    int pm25_points[] = '{0, 12, 13, 35, 36, 55, 56, 150, 151, 250, 251,
                          350, 351, 500, 501, 65535};
    frame_bytes_t f;
    foreach (pm25_points[i]) begin
      build_frame(rand_reading(), 16'(pm25_points[i]), rand_reading(), rand_reading(), f);
      send_frame(f, 0);
    end
    drain_results();
  endtask

  task automatic test_header_resync();
    frame_bytes_t f;
    // wrong byte after 'B', then a clean frame
    send_byte(HDR_B);
    send_byte(8'h00);
    build_frame(16'd1, 16'd2, 16'd3, 16'd4, f);
    send_frame(f, 0);
    // a 'B' breaking the header at each position starts the next frame
    for (int k = 1; k < 4; k++) begin
      for (int i = 0; i < k; i++) send_byte(header_seq[i]);
      build_frame(rand_reading(), rand_reading(), rand_reading(), rand_reading(), f);
      send_frame(f, 0);
    end
    // wrong length byte
    send_byte(HDR_B);
    send_byte(HDR_M);
    send_byte(HDR_ZERO);
    send_byte(HDR_LEN + 8'd1);
    // header pattern inside the payload is not checked
    build_frame(16'h4242, 16'd77, 16'h4D00, 16'h1C42, f);
    for (int i = 0; i < 4; i++) f[10 + i] = header_seq[i];
    send_frame(f, 0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int start_count, pick, k;
    logic [7:0] bad;
    frame_bytes_t f;
    start_count = bytes_sent;
    while (bytes_sent - start_count < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        build_frame(rand_reading(), rand_reading(), rand_reading(), rand_reading(), f);
        send_frame(f, 0);
      end else if (pick < 85) begin
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++) send_byte(header_seq[i]);
        do bad = 8'($urandom_range(255)); while (bad == header_seq[k]);
        send_byte(bad);
      end else begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end
    end
    drain_results();
  endtask

  // receiver holds off long enough for a finished frame to back up the input
  task automatic test_output_backpressure();
    frame_bytes_t f;
    hold_len    = 400;
    hold_toggle = ~hold_toggle;
    repeat (3) begin
      build_frame(rand_reading(), rand_reading(), rand_reading(), rand_reading(), f);
      send_frame(f, 0);
    end
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= hold_len;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading expected none actual pm25 %h aqi %h", $time,
                 out_chan.pm25_value, out_chan.aqi_value);
      end else begin
        want = pending_readings.pop_front();
        check_field("pm1_value",      want.pm1,  out_chan.pm1_value);
        check_field("pm25_value",     want.pm25, out_chan.pm25_value);
        check_field("pm10_value",     want.pm10, out_chan.pm10_value);
        check_field("count_03_value", want.c03,  out_chan.count_03_value);
        check_field("aqi_value",      want.aqi,  out_chan.aqi_value);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d readings outstanding", pending_readings.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_chan.valid   = 1'b0;
    in_chan.rx_byte = 8'h00;
    out_chan.ready  = 1'b0;
    send_idle_pct   = 20;
    recv_stall_pct  = 52;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_index_breakpoints();
    test_header_resync();
    test_random_traffic(20);

    send_idle_pct  = 52;
    recv_stall_pct = 20;
    test_random_traffic(20);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(20);
    test_output_backpressure();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
